FILE: hw/rtl/lgrt_pkg.sv
// Shared types and constants for the lock grant/revoke table.
// Used by lgrt_slot_ram, lgrt_waiter_ram and lock_grant_revoke_table.
`default_nettype none

package lgrt_pkg;

  localparam int LOCK_SLOTS  = 64;
  localparam int CLIENTS     = 16;
  localparam int QUEUE_DEPTH = 16;

  localparam int LOCK_W   = $clog2(LOCK_SLOTS);
  localparam int CLIENT_W = $clog2(CLIENTS);
  localparam int QPOS_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int WADDR_W  = LOCK_W + QPOS_W;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_REVOKING = 2'd2,
    MODE_RETRYING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_RETRY       = 2'd1,
    STAT_BAD_RELEASE = 2'd2,
    STAT_QUEUE_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_REVOKE = 2'd1,
    MSG_RETRY  = 2'd2
  } msg_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SLOT = 2'd1,
    S_EXEC = 2'd2
  } state_t;

  // One lock slot as stored in the slot memory.
  typedef struct packed {
    logic                used;
    mode_t               mode;
    logic [CLIENT_W-1:0] owner;
    logic [CLIENT_W-1:0] retrier;
    logic [QPOS_W-1:0]   head;
    logic [QCNT_W-1:0]   count;
  } slot_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lock_grant_revoke_table.sv
// Lock grant/revoke table: the accepting edge registers the request and reads the lock's
// slot entry, S_SLOT reads the head of its wait queue, and S_EXEC writes both memories back
// and registers the result onto out_*, which is shown with out_valid high for one cycle.
// busy is high in S_SLOT and S_EXEC, so a new request can be started in the cycle the
// previous result is shown. The receiver cannot stall results. Slot state comes out of
// reset through per-slot valid bits; no clearing pass is needed. Uses lgrt_pkg,
// lgrt_slot_ram and lgrt_waiter_ram.
`default_nettype none

module lock_grant_revoke_table
  import lgrt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_op,
  input  wire logic [LOCK_W-1:0]   in_lock_id,
  input  wire logic [CLIENT_W-1:0] in_client_id,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [1:0]               out_msg_kind,
  output logic [CLIENT_W-1:0]      out_msg_client,
  output logic [LOCK_W-1:0]        out_msg_lock
);

  state_t state_r, state_nxt;

  logic                accept;
  op_t                 op_r;
  logic [LOCK_W-1:0]   lock_r;
  logic [CLIENT_W-1:0] client_r;

  slot_t               slot_q;
  slot_t               slot_nxt;
  logic [CLIENT_W-1:0] waiter_q;

  logic                wait_rd_en;
  logic                slot_wr_en;
  logic                wait_wr_en;
  logic [QPOS_W-1:0]   tail_pos;

  status_t             status_nxt;
  msg_t                kind_nxt;
  logic [CLIENT_W-1:0] who_nxt;

  logic                out_valid_r;
  status_t             status_r;
  msg_t                kind_r;
  logic [CLIENT_W-1:0] msg_client_r;
  logic [LOCK_W-1:0]   msg_lock_r;

  assign accept = start && !busy;

  lgrt_slot_ram u_slot_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_lock_id),
    .rd_data (slot_q),
    .wr_en   (slot_wr_en),
    .wr_addr (lock_r),
    .wr_data (slot_nxt)
  );

  assign tail_pos = slot_q.head + slot_q.count[QPOS_W-1:0];

  lgrt_waiter_ram u_waiter_ram (
    .clk     (clk),
    .rd_en   (wait_rd_en),
    .rd_addr ({lock_r, slot_q.head}),
    .rd_data (waiter_q),
    .wr_en   (wait_wr_en),
    .wr_addr ({lock_r, tail_pos}),
    .wr_data (client_r)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_SLOT;
      S_SLOT:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy       = 1'b0;
    wait_rd_en = 1'b0;
    slot_wr_en = 1'b0;
    case (state_r)
      S_IDLE:  busy = 1'b0;
      S_SLOT: begin
        busy       = 1'b1;
        wait_rd_en = 1'b1;
      end
      S_EXEC: begin
        busy       = 1'b1;
        slot_wr_en = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // Protocol decision on the slot entry and the queue head.
  always_comb begin
    slot_nxt   = slot_q;
    status_nxt = STAT_OK;
    kind_nxt   = MSG_NONE;
    who_nxt    = '0;
    wait_wr_en = 1'b0;
    if (op_r == OP_RELEASE) begin
      if (!slot_q.used || slot_q.mode != MODE_REVOKING || slot_q.count == '0) begin
        status_nxt = STAT_BAD_RELEASE;
      end else begin
        slot_nxt.head    = slot_q.head + QPOS_W'(1);
        slot_nxt.count   = slot_q.count - QCNT_W'(1);
        slot_nxt.retrier = waiter_q;
        slot_nxt.mode    = MODE_RETRYING;
        kind_nxt         = MSG_RETRY;
        who_nxt          = waiter_q;
      end
    end else if (!slot_q.used) begin
      slot_nxt.used  = 1'b1;
      slot_nxt.mode  = MODE_LOCKED;
      slot_nxt.owner = client_r;
    end else if (slot_q.mode == MODE_RETRYING && client_r == slot_q.retrier) begin
      slot_nxt.owner = client_r;
      if (slot_q.count != '0) begin
        slot_nxt.mode = MODE_REVOKING;
        kind_nxt      = MSG_REVOKE;
        who_nxt       = client_r;
      end else begin
        slot_nxt.mode = MODE_LOCKED;
      end
    end else if (slot_q.count[QCNT_W-1]) begin
      status_nxt = STAT_QUEUE_FULL;
    end else begin
      wait_wr_en     = (state_r == S_EXEC);
      slot_nxt.count = slot_q.count + QCNT_W'(1);
      status_nxt     = STAT_RETRY;
      if (slot_q.mode != MODE_REVOKING && slot_q.mode != MODE_RETRYING) begin
        // First waiter on a plain held lock: revoke it from the owner.
        slot_nxt.mode = MODE_REVOKING;
        kind_nxt      = MSG_REVOKE;
        who_nxt       = slot_q.owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_op);
      lock_r   <= in_lock_id;
      client_r <= in_client_id;
    end
    if (state_r == S_EXEC) begin
      status_r     <= status_nxt;
      kind_r       <= kind_nxt;
      msg_client_r <= who_nxt;
      msg_lock_r   <= (kind_nxt == MSG_NONE) ? '0 : lock_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_msg_kind   = kind_r;
  assign out_msg_client = msg_client_r;
  assign out_msg_lock   = msg_lock_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lgrt_slot_ram.sv
// Per-lock slot memory with one registered read port and one write port.
// Per-entry valid bits make unwritten slots read as their reset value. Uses lgrt_pkg.
`default_nettype none

module lgrt_slot_ram
  import lgrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [LOCK_W-1:0] rd_addr,
  output slot_t                  rd_data,
  input  wire logic              wr_en,
  input  wire logic [LOCK_W-1:0] wr_addr,
  input  wire slot_t             wr_data
);

  slot_t                 mem [LOCK_SLOTS];
  logic [LOCK_SLOTS-1:0] valid_r;
  slot_t                 data_r;
  logic                  hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= valid_r[rd_addr];
      end
    end
  end

  // A never-written slot is unused with an empty queue; owner and retrier stay as read.
  always_comb begin
    rd_data = data_r;
    if (!hit_r) begin
      rd_data.used  = 1'b0;
      rd_data.mode  = MODE_NONE;
      rd_data.head  = '0;
      rd_data.count = '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lgrt_waiter_ram.sv
// Wait queue storage: one circular buffer of client numbers per lock slot.
// Registered read, single write port. Uses lgrt_pkg.
`default_nettype none

module lgrt_waiter_ram
  import lgrt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [WADDR_W-1:0]  rd_addr,
  output logic [CLIENT_W-1:0]      rd_data,
  input  wire logic                wr_en,
  input  wire logic [WADDR_W-1:0]  wr_addr,
  input  wire logic [CLIENT_W-1:0] wr_data
);

  logic [CLIENT_W-1:0] mem [LOCK_SLOTS*QUEUE_DEPTH];
  logic [CLIENT_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  assign rd_data = data_r;

endmodule

`default_nettype wire

FILE: dv/tb_lock_grant_revoke_table.sv
// Self-checking testbench for lock_grant_revoke_table: a local model of the grant table
// predicts status and message for every accepted request, and a monitor checks each result.
// Depends on lgrt_pkg and the lock_grant_revoke_table RTL only.
`default_nettype none

module tb_lock_grant_revoke_table;
  import lgrt_pkg::*;

  typedef struct packed {
    status_t             status;
    msg_t                kind;
    logic [CLIENT_W-1:0] client;
    logic [LOCK_W-1:0]   lock;
  } grant_answer_t;

  localparam logic [LOCK_W-1:0] TOP_LOCK = LOCK_W'(LOCK_SLOTS - 1);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                in_op = 1'b0;
  logic [LOCK_W-1:0]   in_lock_id = '0;
  logic [CLIENT_W-1:0] in_client_id = '0;
  logic                busy;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [1:0]          out_msg_kind;
  logic [CLIENT_W-1:0] out_msg_client;
  logic [LOCK_W-1:0]   out_msg_lock;

  // Local copy of the lock table that tracks the block's state item by item.
  bit                  lk_used    [LOCK_SLOTS];
  mode_t               lk_mode    [LOCK_SLOTS];
  logic [CLIENT_W-1:0] lk_owner   [LOCK_SLOTS];
  logic [CLIENT_W-1:0] lk_retrier [LOCK_SLOTS];
  logic [CLIENT_W-1:0] lk_waiters [LOCK_SLOTS][QUEUE_DEPTH];
  int                  lk_head    [LOCK_SLOTS];
  int                  lk_count   [LOCK_SLOTS];

  grant_answer_t pending_answers[$];
  int            mismatches = 0;

  lock_grant_revoke_table u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_lock_id    (in_lock_id),
    .in_client_id  (in_client_id),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_msg_kind  (out_msg_kind),
    .out_msg_client(out_msg_client),
    .out_msg_lock  (out_msg_lock)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("lock_grant_revoke_table regression: fail");
    $finish;
  end

  // Applies one request to the local table and returns the answer the block must give.
  function automatic grant_answer_t grant_table_step(op_t op, logic [LOCK_W-1:0] lock,
                                                     logic [CLIENT_W-1:0] who);
    grant_answer_t ans;
    int            slot;
    int            pos;
    ans.status = STAT_OK;
    ans.kind   = MSG_NONE;
    ans.client = '0;
    ans.lock   = '0;
    slot = int'(lock) % LOCK_SLOTS;
    if (op == OP_RELEASE) begin
      if (!lk_used[slot] || lk_mode[slot] != MODE_REVOKING || lk_count[slot] == 0) begin
        ans.status = STAT_BAD_RELEASE;
      end else begin
        ans.kind   = MSG_RETRY;
        ans.client = lk_waiters[slot][lk_head[slot]];
        ans.lock   = lock;
        lk_retrier[slot] = ans.client;
        lk_head[slot]    = (lk_head[slot] + 1) % QUEUE_DEPTH;
        lk_count[slot]   = lk_count[slot] - 1;
        lk_mode[slot]    = MODE_RETRYING;
      end
    end else if (!lk_used[slot]) begin
      lk_used[slot]  = 1'b1;
      lk_mode[slot]  = MODE_LOCKED;
      lk_owner[slot] = who;
    end else if (lk_mode[slot] == MODE_RETRYING && who == lk_retrier[slot]) begin
      lk_owner[slot] = who;
      if (lk_count[slot] > 0) begin
        // The new owner is revoked at once because others are still queued.
        lk_mode[slot] = MODE_REVOKING;
        ans.kind      = MSG_REVOKE;
        ans.client    = who;
        ans.lock      = lock;
      end else begin
        lk_mode[slot] = MODE_LOCKED;
      end
    end else if (lk_count[slot] >= QUEUE_DEPTH) begin
      ans.status = STAT_QUEUE_FULL;
    end else begin
      pos = (lk_head[slot] + lk_count[slot]) % QUEUE_DEPTH;
      lk_waiters[slot][pos] = who;
      lk_count[slot] = lk_count[slot] + 1;
      ans.status = STAT_RETRY;
      // Only the first waiter on a plainly locked slot triggers the revoke.
      if (lk_mode[slot] != MODE_REVOKING && lk_mode[slot] != MODE_RETRYING) begin
        lk_mode[slot] = MODE_REVOKING;
        ans.kind      = MSG_REVOKE;
        ans.client    = lk_owner[slot];
        ans.lock      = lock;
      end
    end
    return ans;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item, with start still high.
  task automatic send_request(op_t op, logic [LOCK_W-1:0] lock, logic [CLIENT_W-1:0] who);
    start        <= 1'b1;
    in_op        <= op;
    in_lock_id   <= lock;
    in_client_id <= who;
    do @(posedge clk); while (busy);
    pending_answers = {pending_answers, grant_table_step(op, lock, who)};
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender off until every predicted answer has been checked or the wait limit runs out.
  task automatic drain(int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_answers.size() > 0 && waited < limit) begin
      @(negedge clk);
      waited++;
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    grant_answer_t exp_ans;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding: status %0d kind %0d", out_status,
               out_msg_kind);
        mismatches++;
      end else begin
        exp_ans = pending_answers[0];
        pending_answers.delete(0);
        if (out_status !== exp_ans.status) begin
          $error("status: expected %0d, got %0d", exp_ans.status, out_status);
          mismatches++;
        end
        if (out_msg_kind !== exp_ans.kind) begin
          $error("msg_kind: expected %0d, got %0d", exp_ans.kind, out_msg_kind);
          mismatches++;
        end
        if (out_msg_client !== exp_ans.client) begin
          $error("msg_client: expected %0d, got %0d", exp_ans.client, out_msg_client);
          mismatches++;
        end
        if (out_msg_lock !== exp_ans.lock) begin
          $error("msg_lock: expected %0d, got %0d", exp_ans.lock, out_msg_lock);
          mismatches++;
        end
      end
    end
  end

  task automatic test_fresh_grants();
    send_request(OP_ACQUIRE, '0, '0);
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(CLIENTS - 1));
    drain(1000);
  endtask

  task automatic test_bad_releases();
    send_request(OP_RELEASE, LOCK_W'(5), CLIENT_W'(9));
    send_request(OP_RELEASE, '0, '0);
    drain(1000);
  endtask

  // Full revoke/retry handoff on the top slot, including a release while retrying
  // and an acquire from a client that was not chosen.
  task automatic test_handoff();
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(3));
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(4));
    send_request(OP_RELEASE, TOP_LOCK, CLIENT_W'(15));
    send_request(OP_RELEASE, TOP_LOCK, CLIENT_W'(15));
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(7));
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(3));
    send_request(OP_RELEASE, TOP_LOCK, CLIENT_W'(3));
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(4));
    send_request(OP_RELEASE, TOP_LOCK, CLIENT_W'(4));
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(7));
    drain(1000);
  endtask

  task automatic test_queue_full();
    for (int c = 0; c < QUEUE_DEPTH; c++) send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(c));
    send_request(OP_ACQUIRE, TOP_LOCK, CLIENT_W'(2));
    send_request(OP_RELEASE, TOP_LOCK, CLIENT_W'(7));
    drain(1000);
  endtask

  // Mostly well-formed traffic on a few hot locks, with some fully random requests.
  task automatic test_random_traffic(int n_items, int max_gap, int release_pct);
    logic [LOCK_W-1:0]   hot [4];
    logic [LOCK_W-1:0]   lock;
    logic [CLIENT_W-1:0] who;
    op_t                 op;
    int                  burst;
    int                  roll;
    burst = $urandom_range(1, 16);
    for (int h = 0; h < 4; h++) hot[h] = LOCK_W'($urandom_range(0, LOCK_SLOTS - 1));
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 99) begin
        hot[$urandom_range(0, 3)] = LOCK_W'($urandom_range(0, LOCK_SLOTS - 1));
      end
      roll = $urandom_range(0, 99);
      lock = hot[$urandom_range(0, 3)];
      who  = CLIENT_W'($urandom_range(0, CLIENTS - 1));
      op   = OP_ACQUIRE;
      if (roll < 20) begin
        op   = op_t'($urandom_range(0, 1));
        lock = LOCK_W'($urandom_range(0, LOCK_SLOTS - 1));
      end else if (lk_used[lock] && lk_mode[lock] == MODE_RETRYING && roll < 65) begin
        who = lk_retrier[lock];
      end else if ($urandom_range(0, 99) < release_pct) begin
        op = OP_RELEASE;
      end
      send_request(op, lock, who);
      burst--;
      if (burst == 0) begin
        if (max_gap > 0) pause_sender($urandom_range(1, max_gap));
        burst = $urandom_range(1, 16);
      end
    end
    drain(1000);
  endtask

  initial begin
    for (int s = 0; s < LOCK_SLOTS; s++) begin
      lk_mode[s]    = MODE_NONE;
      lk_owner[s]   = '0;
      lk_retrier[s] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fresh_grants();
    test_bad_releases();
    test_handoff();
    test_queue_full();
    test_random_traffic(300, 4, 45);
    test_random_traffic(300, 0, 20);
    test_random_traffic(400, 6, 55);
    test_random_traffic(300, 2, 35);
    drain(1000);
    repeat (4) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d results never arrived", pending_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("lock_grant_revoke_table regression: pass");
    end else begin
      $display("lock_grant_revoke_table regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
